// ----- src/gcl_pkg.sv -----
// Shared constants, types and a helper function for the gradient color lookup.
package gcl_pkg;

    // Stop table geometry.
    localparam int TABLE_SIZE    = 7;
    localparam int MAX_STOPS     = 7;
    localparam int IDX_W         = 3;
    localparam int CNT_W         = 3;
    localparam int STOP_W        = 48;
    localparam int STOP_POS_LSB  = 32;
    localparam int POS_FIELD_W   = 16;
    localparam int POS_BITS_DEF  = 16;

    // Color channels: red, green, blue, alpha from the top byte down.
    localparam int CH_W          = 8;
    localparam int CH_COUNT      = 4;

    // Interpolation fraction: Q16, so it spans 0 to 65536 and needs 17 bits.
    localparam int FRAC_BITS     = 16;
    localparam int Q_BITS        = FRAC_BITS + 1;
    localparam int ROUND_HALF    = 1 << (FRAC_BITS - 1);
    localparam int PROD_W        = CH_W + 1 + Q_BITS + 1;

    // Queue between the classifier and the interpolator.
    localparam int QUEUE_DEPTH   = 4;

    // Register port.
    localparam int APB_ADDR_W    = 6;
    localparam int APB_DATA_W    = 64;
    localparam int REG_SEL_LSB   = 3;

    typedef logic [STOP_W-1:0]                 t_stop_word;
    typedef t_stop_word [TABLE_SIZE-1:0]       t_stop_table;

    // Register indexes of the configuration port.
    typedef enum logic [IDX_W-1:0] {
        REG_STOP_COUNT = 3'd0,
        REG_STOP_0     = 3'd1,
        REG_STOP_1     = 3'd2,
        REG_STOP_2     = 3'd3,
        REG_STOP_3     = 3'd4,
        REG_STOP_4     = 3'd5,
        REG_STOP_5     = 3'd6,
        REG_STOP_6     = 3'd7
    } t_reg_index;

    // Reset contents of the registers.
    localparam logic [CNT_W-1:0] COUNT_RESET = 3'd2;
    localparam t_stop_word       STOP0_RESET = 48'h0000_FFFF_FFFF;
    localparam t_stop_word       STOP1_RESET = 48'hFFFF_FFFF_FFFF;

    // Queue occupancy flags seen by both sides of the queue.
    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_status;

    // One color channel of a stop word; channel 0 is red.
    function automatic logic [CH_W-1:0] chan_of(input t_stop_word w, input int c);
        logic [CH_W-1:0] v;
        v = w[(CH_COUNT - 1 - c) * CH_W +: CH_W];
        return v;
    endfunction

endpackage

// ----- src/gcl_front.sv -----
// Classifier: finds the end case or the gradient segment for each position word.
module gcl_front import gcl_pkg::*; #(
    parameter int POSITION_BITS = POS_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [POS_FIELD_W-1:0]   i_position,
    input  logic [CNT_W-1:0]         i_stop_count,
    input  t_stop_table              i_stops,
    input  t_fifo_status             i_queue,
    output logic                     o_push,
    output logic                     o_dir,
    output logic [IDX_W-1:0]         o_idx,
    output logic [POSITION_BITS-1:0] o_x,
    output logic [POSITION_BITS-1:0] o_d
);

    logic [POSITION_BITS-1:0] spos [TABLE_SIZE];
    logic [POSITION_BITS-1:0] pos_in;
    logic [TABLE_SIZE-1:0]    n_ge;
    logic [TABLE_SIZE-1:0]    n_le;
    logic [CNT_W-1:0]         n_count;
    logic                     fe;

    logic                     r_f1_v;
    logic [POSITION_BITS-1:0] r_p;
    logic [TABLE_SIZE-1:0]    r_ge;
    logic [TABLE_SIZE-1:0]    r_le;
    logic [IDX_W-1:0]         r_last;
    logic                     r_one;

    logic                     seg_found;
    logic [IDX_W-1:0]         seg_idx;
    logic [IDX_W-1:0]         seg_nx;
    logic                     n_dir;
    logic [IDX_W-1:0]         n_idx;

    logic                     r_f2_v;
    logic                     r_dir;
    logic [IDX_W-1:0]         r_idx;
    logic [POSITION_BITS-1:0] r_x;
    logic [POSITION_BITS-1:0] r_d;

    // The front advances unless a finished word is waiting on a full queue.
    assign fe      = !(r_f2_v && i_queue.full);
    assign o_stall = !fe;
    assign o_push  = r_f2_v && !i_queue.full;

    // Compare the position against every stop position in parallel.
    always_comb begin
        pos_in = i_position[POSITION_BITS-1:0];
        for (int k = 0; k < TABLE_SIZE; k++) begin
            spos[k] = i_stops[k][STOP_POS_LSB +: POSITION_BITS];
            n_ge[k] = pos_in >= spos[k];
            n_le[k] = pos_in <= spos[k];
        end
        if (i_stop_count == '0) begin
            n_count = CNT_W'(1);
        end else if (i_stop_count > CNT_W'(MAX_STOPS)) begin
            n_count = CNT_W'(MAX_STOPS);
        end else begin
            n_count = i_stop_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v <= 1'b0;
        end else if (fe) begin
            r_f1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fe) begin
            r_p    <= pos_in;
            r_ge   <= n_ge;
            r_le   <= n_le;
            r_last <= n_count - IDX_W'(1);
            r_one  <= n_count == CNT_W'(1);
        end
    end

    // Pick the end case or the first segment that holds the position.
    always_comb begin
        seg_found = 1'b0;
        seg_idx   = '0;
        for (int i = 0; i < TABLE_SIZE - 1; i++) begin
            if (!seg_found && r_ge[i] && r_le[i+1] && (IDX_W'(i) < r_last)) begin
                seg_found = 1'b1;
                seg_idx   = IDX_W'(i);
            end
        end
        seg_nx = seg_idx + IDX_W'(1);
        if (r_one || r_le[0]) begin
            n_dir = 1'b1;
            n_idx = '0;
        end else if (r_ge[r_last]) begin
            n_dir = 1'b1;
            n_idx = r_last;
        end else if (seg_found) begin
            n_dir = 1'b0;
            n_idx = seg_idx;
        end else begin
            n_dir = 1'b1;
            n_idx = r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f2_v <= 1'b0;
        end else if (fe) begin
            r_f2_v <= r_f1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fe) begin
            r_dir <= n_dir;
            r_idx <= n_idx;
            r_x   <= r_p - spos[seg_idx];
            r_d   <= spos[seg_nx] - spos[seg_idx];
        end
    end

    assign o_dir = r_dir;
    assign o_idx = r_idx;
    assign o_x   = r_x;
    assign o_d   = r_d;

endmodule

// ----- src/gcl_fifo.sv -----
// Short word queue between the classifier and the interpolator.
module gcl_fifo import gcl_pkg::*; #(
    parameter int WIDTH = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output t_fifo_status     o_status
);

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0]  r_entries [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wptr;
    logic [PTR_W-1:0]  r_rptr;
    logic [QCNT_W-1:0] r_count;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    // Storage for the queued words.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entries[r_wptr] <= i_wdata;
        end
    end

    assign o_rdata        = r_entries[r_rptr];
    assign o_status.full  = r_count == QCNT_W'(QUEUE_DEPTH);
    assign o_status.empty = r_count == '0;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_status.full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_status.empty)
        else $error("queue read while empty");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue fill count beyond depth");

endmodule

// ----- src/gcl_back.sv -----
// Interpolator: pipelined fraction divider, channel multiply and output register.
module gcl_back import gcl_pkg::*; #(
    parameter int POSITION_BITS = POS_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [IDX_W+2*POSITION_BITS:0]   i_job,
    input  t_fifo_status                     i_queue,
    output logic                             o_pop,
    input  t_stop_table                      i_stops,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [CH_W-1:0]                  o_red,
    output logic [CH_W-1:0]                  o_green,
    output logic [CH_W-1:0]                  o_blue,
    output logic [CH_W-1:0]                  o_alpha
);

    localparam int PB    = POSITION_BITS;
    localparam int JOB_W = IDX_W + 2 * PB + 1;
    localparam int NUM_W = PB + FRAC_BITS;

    logic                 be;
    logic                 job_dir;
    logic [IDX_W-1:0]     job_idx;
    logic [PB-1:0]        job_x;
    logic [PB-1:0]        job_d;
    logic [NUM_W-1:0]     job_num;

    // Divider stages: stage 0 is loaded from the queue, stage Q_BITS holds the quotient.
    logic [Q_BITS:0]      r_v;
    logic                 r_dir  [Q_BITS+1];
    logic [IDX_W-1:0]     r_idx  [Q_BITS+1];
    logic [PB-1:0]        r_d    [Q_BITS+1];
    logic [Q_BITS-1:0]    r_q    [Q_BITS+1];
    logic [PB-1:0]        r_rem  [Q_BITS];
    logic [Q_BITS-1:0]    r_low  [Q_BITS];

    logic [PB:0]          trial  [Q_BITS];
    logic [PB:0]          sub    [Q_BITS];
    logic                 qbit   [Q_BITS];
    logic [PB-1:0]        n_rem  [Q_BITS];

    logic [Q_BITS-1:0]    t_fin;
    logic [IDX_W-1:0]     hi_idx;
    logic [CH_W-1:0]      m_lo   [CH_COUNT];
    logic [CH_W-1:0]      m_hi   [CH_COUNT];
    logic signed [CH_W:0] m_diff [CH_COUNT];
    logic signed [PROD_W-1:0] m_prod [CH_COUNT];

    logic                 r_m_v;
    logic [CH_W-1:0]      r_m_lo   [CH_COUNT];
    logic signed [PROD_W-1:0] r_m_prod [CH_COUNT];

    logic signed [PROD_W:0] y_sum  [CH_COUNT];
    logic signed [PROD_W:0] y_sh   [CH_COUNT];
    logic [CH_W-1:0]      n_ch   [CH_COUNT];

    logic                 r_out_v;
    logic [CH_W-1:0]      r_ch   [CH_COUNT];

    // The whole back end holds while a result waits on a stalled output.
    assign be    = !(r_out_v && i_stall);
    assign o_pop = be && !i_queue.empty;

    // Unpack the queued word and build the rounded dividend.
    always_comb begin
        job_dir = i_job[JOB_W-1];
        job_idx = i_job[JOB_W-2 -: IDX_W];
        job_x   = i_job[2*PB-1 -: PB];
        job_d   = i_job[PB-1:0];
        job_num = {job_x, {FRAC_BITS{1'b0}}} + NUM_W'(job_d >> 1);
    end

    // One restoring division step per stage.
    always_comb begin
        for (int s = 0; s < Q_BITS; s++) begin
            trial[s] = {r_rem[s], r_low[s][Q_BITS-1]};
            sub[s]   = trial[s] - {1'b0, r_d[s]};
            qbit[s]  = trial[s] >= {1'b0, r_d[s]};
            n_rem[s] = qbit[s] ? sub[s][PB-1:0] : trial[s][PB-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (be) begin
            r_v <= {r_v[Q_BITS-1:0], o_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (be) begin
            r_dir[0] <= job_dir;
            r_idx[0] <= job_idx;
            r_d[0]   <= job_d;
            r_q[0]   <= '0;
            r_rem[0] <= {1'b0, job_num[NUM_W-1:Q_BITS]};
            r_low[0] <= job_num[Q_BITS-1:0];
            for (int s = 0; s < Q_BITS; s++) begin
                r_dir[s+1] <= r_dir[s];
                r_idx[s+1] <= r_idx[s];
                r_d[s+1]   <= r_d[s];
                r_q[s+1]   <= {r_q[s][Q_BITS-2:0], qbit[s]};
                if (s + 1 < Q_BITS) begin
                    r_rem[s+1] <= n_rem[s];
                    r_low[s+1] <= {r_low[s][Q_BITS-2:0], 1'b0};
                end
            end
        end
    end

    // Channel products: the difference of the two stop colors times the fraction.
    // A direct stop color and a zero-length segment use a fraction of zero.
    always_comb begin
        if (r_dir[Q_BITS] || (r_d[Q_BITS] == '0)) begin
            t_fin = '0;
        end else begin
            t_fin = r_q[Q_BITS];
        end
        hi_idx = r_dir[Q_BITS] ? r_idx[Q_BITS] : r_idx[Q_BITS] + IDX_W'(1);
        for (int c = 0; c < CH_COUNT; c++) begin
            m_lo[c]   = chan_of(i_stops[r_idx[Q_BITS]], c);
            m_hi[c]   = chan_of(i_stops[hi_idx], c);
            m_diff[c] = $signed({1'b0, m_hi[c]}) - $signed({1'b0, m_lo[c]});
            m_prod[c] = m_diff[c] * $signed({1'b0, t_fin});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v <= 1'b0;
        end else if (be) begin
            r_m_v <= r_v[Q_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (be) begin
            for (int c = 0; c < CH_COUNT; c++) begin
                r_m_lo[c]   <= m_lo[c];
                r_m_prod[c] <= m_prod[c];
            end
        end
    end

    // Round the product to nearest and add it to the lower stop color.
    always_comb begin
        for (int c = 0; c < CH_COUNT; c++) begin
            y_sum[c] = r_m_prod[c] + $signed((PROD_W + 1)'(ROUND_HALF));
            y_sh[c]  = y_sum[c] >>> FRAC_BITS;
            n_ch[c]  = r_m_lo[c] + y_sh[c][CH_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (be) begin
            r_out_v <= r_m_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (be && r_m_v) begin
            for (int c = 0; c < CH_COUNT; c++) begin
                r_ch[c] <= n_ch[c];
            end
        end
    end

    assign o_valid = r_out_v;
    assign o_red   = r_ch[0];
    assign o_green = r_ch[1];
    assign o_blue  = r_ch[2];
    assign o_alpha = r_ch[3];

    a_frac_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[Q_BITS] && !r_dir[Q_BITS] && (r_d[Q_BITS] != '0))
            |-> (r_q[Q_BITS] <= Q_BITS'(1 << FRAC_BITS)))
        else $error("interpolation fraction above one");

    a_freeze_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && i_stall) |=> ($stable(r_v) && $stable(r_m_v)))
        else $error("back pipeline moved while the output was stalled");

    a_pop_loads_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_v[0])
        else $error("word taken from the queue was lost");

endmodule

// ----- src/gradient_color_lookup_top.sv -----
// Top level of the gradient color lookup: register port, classifier, queue, interpolator.
//
//  Channel   Direction  Handshake                  Word
//  input     in         i_valid / o_stall          i_position
//  output    out        o_valid / i_stall          o_red, o_green, o_blue, o_alpha
//  config    in         psel, penable, pwrite      paddr, pwdata, prdata (48-bit stop words on a 64-bit bus)
//
// One position word is taken per cycle and one color word leaves per cycle while nothing stalls.
// A result passes through the classifier registers, the queue, the 17-stage fraction
// divider, the product register and the output register; the divider is most of that path.
// A four-word queue parts the classifier from the interpolator, so each side holds
// on its own; a stalled output freezes the interpolator and fills the queue first.
// Reset is synchronous and active low and loads the stop table with opaque white.
module gradient_color_lookup_top import gcl_pkg::*; #(
    parameter int POSITION_BITS = POS_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [POS_FIELD_W-1:0] i_position,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [CH_W-1:0]        o_red,
    output logic [CH_W-1:0]        o_green,
    output logic [CH_W-1:0]        o_blue,
    output logic [CH_W-1:0]        o_alpha,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    localparam int JOB_W = IDX_W + 2 * POSITION_BITS + 1;

    // Stop table after reset: the first two stops are opaque white, the rest zero.
    localparam t_stop_table STOPS_RESET =
        {{((TABLE_SIZE - 2) * STOP_W){1'b0}}, STOP1_RESET, STOP0_RESET};

    logic [CNT_W-1:0]         r_stop_count;
    t_stop_table              r_stops;
    t_reg_index               reg_sel;
    logic                     cfg_wr;

    logic                     push;
    logic                     pop;
    logic                     f_dir;
    logic [IDX_W-1:0]         f_idx;
    logic [POSITION_BITS-1:0] f_x;
    logic [POSITION_BITS-1:0] f_d;
    logic [JOB_W-1:0]         q_rdata;
    t_fifo_status             q_status;

    // Register port: zero wait states, write on the access cycle.
    assign pready  = 1'b1;
    assign reg_sel = t_reg_index'(paddr[REG_SEL_LSB +: IDX_W]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop_count <= COUNT_RESET;
            r_stops      <= STOPS_RESET;
        end else if (cfg_wr) begin
            if (reg_sel == REG_STOP_COUNT) begin
                r_stop_count <= pwdata[CNT_W-1:0];
            end else begin
                r_stops[reg_sel - IDX_W'(REG_STOP_0)] <= pwdata[STOP_W-1:0];
            end
        end
    end

    // Read back of the register selected by the address.
    always_comb begin
        case (reg_sel)
            REG_STOP_COUNT: prdata = APB_DATA_W'(r_stop_count);
            REG_STOP_0:     prdata = APB_DATA_W'(r_stops[0]);
            REG_STOP_1:     prdata = APB_DATA_W'(r_stops[1]);
            REG_STOP_2:     prdata = APB_DATA_W'(r_stops[2]);
            REG_STOP_3:     prdata = APB_DATA_W'(r_stops[3]);
            REG_STOP_4:     prdata = APB_DATA_W'(r_stops[4]);
            REG_STOP_5:     prdata = APB_DATA_W'(r_stops[5]);
            REG_STOP_6:     prdata = APB_DATA_W'(r_stops[6]);
            default:        prdata = '0;
        endcase
    end

    // Classifier.
    gcl_front #(
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_position   (i_position),
        .i_stop_count (r_stop_count),
        .i_stops      (r_stops),
        .i_queue      (q_status),
        .o_push       (push),
        .o_dir        (f_dir),
        .o_idx        (f_idx),
        .o_x          (f_x),
        .o_d          (f_d)
    );

    // Queue of classified words.
    gcl_fifo #(
        .WIDTH (JOB_W)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_wdata  ({f_dir, f_idx, f_x, f_d}),
        .i_pop    (pop),
        .o_rdata  (q_rdata),
        .o_status (q_status)
    );

    // Interpolator.
    gcl_back #(
        .POSITION_BITS (POSITION_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (q_rdata),
        .i_queue (q_status),
        .o_pop   (pop),
        .i_stops (r_stops),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_red   (o_red),
        .o_green (o_green),
        .o_blue  (o_blue),
        .o_alpha (o_alpha)
    );

endmodule

// ----- verif/gradient_color_checker.sv -----
`timescale 1ns / 1ps
// Checker for the gradient color lookup: predicts every color word and compares it.
module gradient_color_checker import gcl_pkg::*; #(
    parameter int POSITION_BITS = POS_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_position_valid,
    input  logic                   i_position_stall,
    input  logic [POS_FIELD_W-1:0] i_position,
    input  logic                   i_color_valid,
    input  logic                   i_color_stall,
    input  logic [CH_W-1:0]        i_red,
    input  logic [CH_W-1:0]        i_green,
    input  logic [CH_W-1:0]        i_blue,
    input  logic [CH_W-1:0]        i_alpha,
    input  logic                   i_psel,
    input  logic                   i_penable,
    input  logic                   i_pwrite,
    input  logic [APB_ADDR_W-1:0]  i_paddr,
    input  logic [APB_DATA_W-1:0]  i_pwdata,
    input  logic [APB_DATA_W-1:0]  i_prdata,
    input  logic                   i_pready,
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_checked
);

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] alpha;
    } t_color;

    localparam logic [POS_FIELD_W-1:0] POS_MASK = POS_FIELD_W'((32'd1 << POSITION_BITS) - 1);
    localparam logic [63:0]            Q_ONE    = 64'd1 << FRAC_BITS;
    localparam int                     MAX_LINES = 50;

    string            channel_names [CH_COUNT] = '{"red", "green", "blue", "alpha"};
    logic [CNT_W-1:0] stop_count;
    t_stop_word       stop_table [TABLE_SIZE];
    t_color           expected_colors [$];
    int               fail_count = 0;
    int               accepted = 0;
    int               checked = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = accepted - checked;
    assign o_checked    = checked;

    // Prints one line per mismatch, up to a cap, and counts every one.
    task automatic report_mismatch(input string what);
        if (fail_count < MAX_LINES) begin
            $display("%0t ns mismatch: %s", $time, what);
        end
        fail_count++;
    endtask

    // Position field of a stop, trimmed to the position width in use.
    function automatic logic [POS_FIELD_W-1:0] stop_position(input int k);
        return stop_table[k][STOP_POS_LSB +: POS_FIELD_W] & POS_MASK;
    endfunction

    // Expected color for one position under the current stop table.
    function automatic t_color predict_color(input logic [POS_FIELD_W-1:0] position);
        int                     used;
        int                     last_stop;
        logic [POS_FIELD_W-1:0] p;
        logic [POS_FIELD_W-1:0] a;
        logic [POS_FIELD_W-1:0] b;
        logic [63:0]            span;
        logic [63:0]            frac;
        logic [63:0]            lo;
        logic [63:0]            hi;
        logic [63:0]            mixed;
        logic [31:0]            color;
        p = position & POS_MASK;
        // A count of zero acts as one stop; larger counts clamp to the table.
        used = (stop_count == 0) ? 1 : int'(stop_count);
        if (used > MAX_STOPS) begin
            used = MAX_STOPS;
        end
        last_stop = used - 1;
        if (used == 1 || p <= stop_position(0)) begin
            return t_color'(stop_table[0][31:0]);
        end
        if (p >= stop_position(last_stop)) begin
            return t_color'(stop_table[last_stop][31:0]);
        end
        // First ascending segment that holds the position wins.
        for (int k = 0; k < last_stop; k++) begin
            a = stop_position(k);
            b = stop_position(k + 1);
            if (p >= a && p <= b) begin
                span = 64'(b) - 64'(a);
                frac = '0;
                if (span != 0) begin
                    frac = (((64'(p) - 64'(a)) << FRAC_BITS) + (span >> 1)) / span;
                end
                if (frac > Q_ONE) begin
                    frac = Q_ONE;
                end
                for (int c = 0; c < CH_COUNT; c++) begin
                    lo = 64'(stop_table[k][(CH_COUNT - 1 - c) * CH_W +: CH_W]);
                    hi = 64'(stop_table[k + 1][(CH_COUNT - 1 - c) * CH_W +: CH_W]);
                    mixed = (lo * (Q_ONE - frac) + hi * frac + 64'(ROUND_HALF)) >> FRAC_BITS;
                    color[(CH_COUNT - 1 - c) * CH_W +: CH_W] = mixed[CH_W-1:0];
                end
                return t_color'(color);
            end
        end
        // No segment holds it: fall back to the last stop.
        return t_color'(stop_table[last_stop][31:0]);
    endfunction

    // Watch the register port and both word channels at every rising edge.
    always @(posedge i_clk) begin : watch
        t_color                got;
        t_color                want;
        t_reg_index            index;
        logic [APB_DATA_W-1:0] stored;
        if (!i_rst_n) begin
            stop_count = COUNT_RESET;
            for (int k = 0; k < TABLE_SIZE; k++) begin
                stop_table[k] = '0;
            end
            stop_table[0] = STOP0_RESET;
            stop_table[1] = STOP1_RESET;
            expected_colors.delete();
            accepted = 0;
            checked = 0;
        end else begin
            // Register access: writes update the local copy, reads are compared with it.
            index = t_reg_index'(i_paddr[REG_SEL_LSB +: IDX_W]);
            if (index == REG_STOP_COUNT) begin
                stored = APB_DATA_W'(stop_count);
            end else begin
                stored = APB_DATA_W'(stop_table[int'(index) - 1]);
            end
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    if (index == REG_STOP_COUNT) begin
                        stop_count = i_pwdata[CNT_W-1:0];
                    end else begin
                        stop_table[int'(index) - 1] = i_pwdata[STOP_W-1:0];
                    end
                end else if (i_prdata !== stored) begin
                    report_mismatch($sformatf("read of %s returned %h, expected %h",
                                              index.name(), i_prdata, stored));
                end
            end

            // Accepted position word: queue its predicted color.
            if (i_position_valid && !i_position_stall) begin
                expected_colors.push_back(predict_color(i_position));
                accepted++;
            end

            // Accepted color word: compare each channel with the oldest prediction.
            if (i_color_valid && !i_color_stall) begin
                got = {i_red, i_green, i_blue, i_alpha};
                if (expected_colors.size() == 0) begin
                    report_mismatch($sformatf("color word %h with no position waiting", got));
                end else begin
                    want = expected_colors.pop_front();
                    checked++;
                    for (int c = 0; c < CH_COUNT; c++) begin
                        if (got[(CH_COUNT - 1 - c) * CH_W +: CH_W] !==
                            want[(CH_COUNT - 1 - c) * CH_W +: CH_W]) begin
                            report_mismatch($sformatf("color %0d %s is %h, expected %h",
                                checked, channel_names[c],
                                got[(CH_COUNT - 1 - c) * CH_W +: CH_W],
                                want[(CH_COUNT - 1 - c) * CH_W +: CH_W]));
                        end
                    end
                end
            end
        end
    end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// Stimulus and verdict for the gradient color lookup, with the checker beside the block.
module testbench;
    import gcl_pkg::*;

    localparam int  RANDOM_PHASES = 10;
    localparam int  PHASE_ITEMS   = 60;
    localparam int  DRAIN_CYCLES  = 30;
    localparam int  IDLE_PERCENT  = 32;
    localparam int  RESET_CYCLES  = 8;
    localparam time TIMEOUT_NS    = 2_000_000;

    logic                   i_clk;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic                   o_stall;
    logic [POS_FIELD_W-1:0] i_position = '0;
    logic                   o_valid;
    logic                   i_stall = 1'b0;
    logic [CH_W-1:0]        o_red;
    logic [CH_W-1:0]        o_green;
    logic [CH_W-1:0]        o_blue;
    logic [CH_W-1:0]        o_alpha;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr = '0;
    logic [APB_DATA_W-1:0]  pwdata = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    int                     fail_count;
    int                     pending;
    int                     checked;
    bit                     steady = 1'b0;
    int                     settings_loaded = 0;
    int                     register_accesses = 0;
    t_stop_table            loaded_words;

    gradient_color_lookup_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_position (i_position),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_red      (o_red),
        .o_green    (o_green),
        .o_blue     (o_blue),
        .o_alpha    (o_alpha),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    gradient_color_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_position_valid (i_valid),
        .i_position_stall (o_stall),
        .i_position       (i_position),
        .i_color_valid    (o_valid),
        .i_color_stall    (i_stall),
        .i_red            (o_red),
        .i_green          (o_green),
        .i_blue           (o_blue),
        .i_alpha          (o_alpha),
        .i_psel           (psel),
        .i_penable        (penable),
        .i_pwrite         (pwrite),
        .i_paddr          (paddr),
        .i_pwdata         (pwdata),
        .i_prdata         (prdata),
        .i_pready         (pready),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_checked        (checked)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The color receiver stalls at random except during the steady stretch.
    always @(negedge i_clk) begin
        i_stall <= !steady && ($urandom_range(99) < IDLE_PERCENT);
    end

    // Sends one position word, idling at random first, and returns at the next falling edge.
    task automatic send_position(input logic [POS_FIELD_W-1:0] position);
        while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_position <= position;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    // Holds the sender back until every expected color has come out.
    task automatic drain();
        i_valid <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (pending != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // One register access: setup cycle, then access cycle until pready.
    task automatic bus_access(input bit is_write, input t_reg_index index,
                              input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= APB_ADDR_W'(index) << REG_SEL_LSB;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        register_accesses++;
    endtask

    // Loads a whole stop table once the block is idle, then reads every register back.
    task automatic load_table(input logic [CNT_W-1:0] count, input t_stop_table words);
        logic [APB_DATA_W-1:0] spare;
        drain();
        // Bits above the register width are sometimes set; the block must drop them.
        spare = ($urandom_range(7) == 0) ? (64'($urandom) << CNT_W) : '0;
        bus_access(1'b1, REG_STOP_COUNT, APB_DATA_W'(count) | spare);
        for (int k = 0; k < TABLE_SIZE; k++) begin
            spare = ($urandom_range(7) == 0) ? (64'($urandom) << STOP_W) : '0;
            bus_access(1'b1, t_reg_index'(k + 1), APB_DATA_W'(words[k]) | spare);
        end
        for (int k = 0; k <= TABLE_SIZE; k++) begin
            bus_access(1'b0, t_reg_index'(k), '0);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        loaded_words = words;
        settings_loaded++;
    endtask

    // Stimulus: directed probes of each stop layout, then random tables and positions.
    initial begin
        t_stop_table            words;
        logic [CNT_W-1:0]       count;
        logic [POS_FIELD_W-1:0] position;
        logic [31:0]            color;
        int                     cursor;
        int                     mode;
        int                     step;
        bit                     sorted;

        loaded_words = '0;
        loaded_words[0] = STOP0_RESET;
        loaded_words[1] = STOP1_RESET;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset table: opaque white from end to end.
        send_position(16'h0000);
        send_position(16'hFFFF);
        send_position(16'h8000);

        // Seven stops with a zero-length segment and extreme channel values.
        words = {48'hFFF0_0102_0304, 48'hC000_8040_2010, 48'h8001_0000_0000,
                 48'h8000_FFFF_FFFF, 48'h2000_1234_5678, 48'h2000_00FF_0000,
                 48'h0010_FF00_80FF};
        load_table(3'd7, words);
        send_position(16'h0000);
        send_position(16'h0010);
        send_position(16'h1008);
        send_position(16'h2000);
        send_position(16'h4000);
        send_position(16'h8000);
        send_position(16'h8001);
        send_position(16'hA000);
        send_position(16'hFFEF);
        send_position(16'hFFFF);

        // A single stop, and a count of zero that acts as one stop.
        load_table(3'd1, words);
        send_position(16'h0000);
        send_position(16'h7777);
        load_table(3'd0, words);
        send_position(16'hFFFF);

        // Unsorted stops: the descending segment is skipped by the scan.
        words = '0;
        words[0] = 48'h1000_FF00_0000;
        words[1] = 48'h3000_00FF_0000;
        words[2] = 48'h2000_0000_FF00;
        words[3] = 48'h8000_0000_00FF;
        load_table(3'd4, words);
        send_position(16'h2800);
        send_position(16'h5000);

        // First stop above the last one.
        words[0] = 48'h8000_1122_3344;
        words[1] = 48'h2000_AABB_CCDD;
        load_table(3'd2, words);
        send_position(16'h1000);
        send_position(16'h9000);

        // Random tables, mostly sorted, with positions aimed near the stops.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            count  = ($urandom_range(99) < 10) ? CNT_W'($urandom_range(1)) :
                                                 CNT_W'($urandom_range(7, 2));
            sorted = $urandom_range(99) < 80;
            cursor = $urandom_range(16'h3000);
            for (int k = 0; k < TABLE_SIZE; k++) begin
                if (sorted) begin
                    step = ($urandom_range(9) == 0) ? 0 : $urandom_range(16'h4000);
                    if (k > 0) begin
                        cursor = (cursor + step > 16'hFFFF) ? 16'hFFFF : cursor + step;
                    end
                end else begin
                    cursor = $urandom_range(16'hFFFF);
                end
                if ($urandom_range(3) == 0) begin
                    color = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;
                end else begin
                    color = $urandom;
                end
                words[k] = {16'(cursor), color};
            end
            load_table(count, words);
            steady = (phase == 4 || phase == 5);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Once mid-phase, wait for every color before going on.
                if (phase == 2 && n == PHASE_ITEMS / 2) begin
                    drain();
                end
                mode = $urandom_range(99);
                if (mode < 40) begin
                    position = $urandom_range(16'hFFFF);
                end else if (mode < 85) begin
                    position = loaded_words[$urandom_range(TABLE_SIZE - 1)][STOP_POS_LSB +: 16];
                    if (mode < 75) begin
                        position = position + 16'($urandom_range(8)) - 16'd4;
                    end
                end else begin
                    position = ($urandom_range(1) ? 16'hFFFF : 16'h0000) ^ 16'($urandom_range(1));
                end
                send_position(position);
            end
        end

        // Let every color come out, then give the verdict.
        drain();
        $display("Checked %0d colors over %0d stop tables with %0d register accesses.",
                 checked, settings_loaded, register_accesses);
        $display("Tables ranged from one stop to seven, sorted and unsorted, with read-back.");
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Hard limit on the run.
    initial begin
        #(TIMEOUT_NS);
        $display("Timed out with %0d colors still expected.", pending);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
